// ===== rtl/psrf_pkg.sv =====
// shared types and constants for the polynomial secant root finder
// no dependencies
`default_nettype none
package psrf_pkg;
  localparam int unsigned MaxDegree = 10;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoefAw    = 4;

  localparam logic [1:0] StConverged = 2'd0;
  localparam logic [1:0] StBracket   = 2'd1;
  localparam logic [1:0] StLimit     = 2'd2;
  localparam logic [1:0] StZeroDen   = 2'd3;

  localparam logic [1:0] CfgDegree = 2'd0;
  localparam logic [1:0] CfgTol    = 2'd1;
  localparam logic [1:0] CfgMaxIt  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_INIT, S_EV_MUL, S_EV_ADD, S_EV_DONE,
    S_CHECK, S_DIV_INIT, S_DIV_RUN, S_UPDATE, S_TEST, S_OUT
  } state_e;

  // which x the evaluator uses and where f goes
  typedef enum logic [1:0] {
    EV_X0, EV_X1, EV_X2
  } ev_sel_e;

  typedef struct packed {
    logic    load_x;
    logic    ev_init;
    ev_sel_e ev_sel;
    logic    ev_mul;
    logic    ev_add;
    logic    ev_store;
    logic    div_init;
    logic    div_step;
    logic    update;
    logic    shift;
    logic    it_clr;
  } cmd_t;

  typedef struct packed {
    logic deg_zero;
    logic ev_last;
    logic div_done;
    logic bracket_bad;
    logic f_equal;
    logic conv;
    logic it_limit;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/polynomial_secant_root_finder.sv =====
// top level: stream ports, config registers, controller and datapath
// depends on psrf_pkg, psrf_ctrl, psrf_datapath
`default_nettype none
// a solve beat runs serially: each evaluation of f uses one shared 32x32
// multiplier in Horner steps, and each secant update adds a restoring
// divider pass. the result beat waits in place until taken; no new beat
// is accepted while a solve is in progress.
module polynomial_secant_root_finder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // coef_index, value_a, value_b, zero pad
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // root, iterations_used, status, zero pad
);
  logic [3:0] degree_q; logic [15:0] tol_q; logic [7:0] maxit_q;
  logic acc, start, busy, ovalid;
  logic [1:0] status;
  logic signed [31:0] root;
  logic [7:0] iters;
  psrf_pkg::cmd_t cmd;
  psrf_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 4'd0; tol_q <= 16'd1; maxit_q <= 8'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psrf_pkg::CfgDegree: degree_q <= cfg_data_i[3:0];
        psrf_pkg::CfgTol:    tol_q    <= cfg_data_i;
        psrf_pkg::CfgMaxIt:  maxit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy;
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign start = acc && s_axis_tuser;

  psrf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .busy_o(busy), .out_valid_o(ovalid), .status_o(status)
  );

  psrf_datapath u_dp (
    .clk_i, .rst_ni,
    .coef_we_i(acc && !s_axis_tuser), .coef_idx_i(s_axis_tdata[3:0]),
    .coef_val_i(s_axis_tdata[35:4]), .xa_i(s_axis_tdata[35:4]),
    .xb_i(s_axis_tdata[67:36]), .degree_i(degree_q), .tol_i(tol_q),
    .max_it_i(maxit_q), .cmd_i(cmd), .sts_o(sts), .root_o(root), .iters_o(iters)
  );

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {6'd0, status, iters, root};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept during result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("solve did not start");
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> iters <= maxit_q) else $error("iteration overrun");
endmodule
`default_nettype wire

// ===== rtl/psrf_datapath.sv =====
// datapath: coefficient store, horner evaluator, serial divider, secant update
// depends on psrf_pkg
`default_nettype none
module psrf_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 coef_we_i,
  input  wire logic [3:0]           coef_idx_i,
  input  wire logic signed [31:0]   coef_val_i,
  input  wire logic signed [31:0]   xa_i,
  input  wire logic signed [31:0]   xb_i,
  input  wire logic [3:0]           degree_i,
  input  wire logic [15:0]          tol_i,
  input  wire logic [7:0]           max_it_i,
  input  wire psrf_pkg::cmd_t       cmd_i,
  output psrf_pkg::sts_t            sts_o,
  output logic signed [31:0]        root_o,
  output logic [7:0]                iters_o
);
  logic signed [31:0] coef_q [psrf_pkg::MaxDegree+1];
  logic [psrf_pkg::MaxDegree:0] cvalid_q;
  logic signed [31:0] x0_q, x1_q, x2_q, f0_q, f1_q, f2_q, acc_q, root_q;
  logic signed [63:0] prod_q;
  logic [3:0] idx_q, deg;
  logic [7:0] it_q;
  logic signed [31:0] xe, cval;
  // divider
  logic [97:0] num_q;        // magnitude of f1*(x1-x0), up to 63 bits
  logic [97:0] quo_q;
  logic [33:0] den_q;
  logic [98:0] rem_q;
  logic [6:0]  dcnt_q;
  logic        neg_q;
  logic signed [32:0] dx, df;
  logic signed [65:0] pnum;
  logic [98:0] rtry;
  logic signed [65:0] sum, stepc, x2w, step;
  logic [33:0] dxa;

  function automatic logic signed [31:0] cval_at(input logic [3:0] i);
    return cvalid_q[i] ? coef_q[i] : '0;
  endfunction

  assign deg = (degree_i > 4'(psrf_pkg::MaxDegree)) ? 4'(psrf_pkg::MaxDegree) : degree_i;
  always_comb begin
    case (cmd_i.ev_sel)
      psrf_pkg::EV_X0: xe = x0_q;
      psrf_pkg::EV_X1: xe = x1_q;
      default:         xe = x2_q;
    endcase
  end
  assign cval = cvalid_q[idx_q] ? coef_q[idx_q] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (coef_we_i && coef_idx_i <= 4'(psrf_pkg::MaxDegree)) begin
      cvalid_q[coef_idx_i] <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (coef_we_i && coef_idx_i <= 4'(psrf_pkg::MaxDegree)) coef_q[coef_idx_i] <= coef_val_i;
  end

  assign dx   = 33'(x1_q) - 33'(x0_q);
  assign df   = 33'(f1_q) - 33'(f0_q);
  assign pnum = 66'(f1_q) * 66'(dx);
  assign rtry = {rem_q[97:0], num_q[97]} - {65'd0, den_q};
  assign sum  = 66'(psrf_pkg::sat32(66'((prod_q + 64'sd32768) >>> psrf_pkg::FracBits)))
              + 66'(cval);
  assign step = neg_q ? -$signed({1'b0, quo_q[64:0]}) : $signed({1'b0, quo_q[64:0]});
  assign stepc = (|quo_q[97:34]) ? (neg_q ? -66'sd8589934592 : 66'sd8589934592) :
                 ((step > 66'sd8589934592) ? 66'sd8589934592 :
                  (step < -66'sd8589934592) ? -66'sd8589934592 : step);
  assign x2w = 66'(x1_q) - stepc;
  assign dxa = (33'(x2_q) - 33'(x1_q)) < 0 ? 34'(-(33'(x2_q) - 33'(x1_q)))
                                           : 34'(33'(x2_q) - 33'(x1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.it_clr) begin
      it_q <= '0;
    end else if (cmd_i.update) begin
      it_q <= it_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x0_q <= xa_i; x1_q <= xb_i; root_q <= xb_i;
    end
    if (cmd_i.ev_init) begin
      acc_q <= cval_at(deg); idx_q <= deg;
    end
    if (cmd_i.ev_mul) begin
      prod_q <= 64'(acc_q) * 64'(xe); idx_q <= idx_q - 4'd1;
    end
    if (cmd_i.ev_add) acc_q <= psrf_pkg::sat32(sum);
    if (cmd_i.ev_store) begin
      case (cmd_i.ev_sel)
        psrf_pkg::EV_X0: f0_q <= acc_q;
        psrf_pkg::EV_X1: f1_q <= acc_q;
        default:         f2_q <= acc_q;
      endcase
    end
    if (cmd_i.div_init) begin
      num_q  <= 98'(pnum < 0 ? -pnum : pnum);
      den_q  <= 34'(df < 0 ? -df : df);
      neg_q  <= (pnum < 0) ^ (df < 0);
      rem_q  <= '0; quo_q <= '0; dcnt_q <= 7'd98;
    end
    if (cmd_i.div_step) begin
      if (!rtry[98]) rem_q <= rtry;
      else           rem_q <= {rem_q[97:0], num_q[97]};
      num_q  <= {num_q[96:0], 1'b0};
      quo_q  <= {quo_q[96:0], ~rtry[98]};
      dcnt_q <= dcnt_q - 7'd1;
    end
    if (cmd_i.update) begin
      x2_q <= psrf_pkg::sat32(x2w); root_q <= psrf_pkg::sat32(x2w);
    end
    if (cmd_i.shift) begin
      x0_q <= x1_q; f0_q <= f1_q; x1_q <= x2_q; f1_q <= f2_q;
    end
  end

  always_comb begin
    sts_o.deg_zero    = (deg == 4'd0);
    sts_o.ev_last     = (idx_q == 4'd0);
    sts_o.div_done    = (dcnt_q == 7'd0);
    sts_o.bracket_bad = (f0_q > 0 && f1_q > 0) || (f0_q < 0 && f1_q < 0);
    sts_o.f_equal     = (f1_q == f0_q);
    sts_o.conv        = (dxa < 34'(tol_i)) ||
                        ((f2_q < 0 ? 33'(-33'(f2_q)) : 33'(f2_q)) < 33'(tol_i));
    sts_o.it_limit    = (it_q >= max_it_i);
  end
  assign root_o  = root_q;
  assign iters_o = it_q;
endmodule
`default_nettype wire

// ===== rtl/psrf_ctrl.sv =====
// controller state machine sequencing evaluation, division and update
// depends on psrf_pkg
`default_nettype none
module psrf_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire psrf_pkg::sts_t  sts_i,
  input  wire logic            out_ready_i,
  output psrf_pkg::cmd_t       cmd_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  output logic [1:0]           status_o
);
  psrf_pkg::state_e   state_q, state_d;
  psrf_pkg::ev_sel_e  sel_q, sel_d;
  logic [1:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psrf_pkg::S_IDLE; sel_q <= psrf_pkg::EV_X0;
      st_q <= psrf_pkg::StConverged;
    end else begin
      state_q <= state_d; sel_q <= sel_d; st_q <= st_d;
    end
  end

  always_comb begin
    state_d = state_q; sel_d = sel_q; st_d = st_q;
    case (state_q)
      psrf_pkg::S_IDLE: if (start_i) begin
        state_d = psrf_pkg::S_EV_INIT; sel_d = psrf_pkg::EV_X0;
      end
      psrf_pkg::S_EV_INIT: state_d = sts_i.deg_zero ? psrf_pkg::S_EV_DONE : psrf_pkg::S_EV_MUL;
      psrf_pkg::S_EV_MUL:  state_d = psrf_pkg::S_EV_ADD;
      psrf_pkg::S_EV_ADD:  state_d = sts_i.ev_last ? psrf_pkg::S_EV_DONE : psrf_pkg::S_EV_MUL;
      psrf_pkg::S_EV_DONE: begin
        if (sel_q == psrf_pkg::EV_X0) begin
          sel_d = psrf_pkg::EV_X1; state_d = psrf_pkg::S_EV_INIT;
        end else if (sel_q == psrf_pkg::EV_X1) begin
          state_d = psrf_pkg::S_CHECK;
        end else begin
          state_d = psrf_pkg::S_TEST;
        end
      end
      psrf_pkg::S_CHECK: begin
        if (sts_i.bracket_bad) begin
          st_d = psrf_pkg::StBracket; state_d = psrf_pkg::S_OUT;
        end else begin
          state_d = psrf_pkg::S_DIV_INIT;
        end
      end
      psrf_pkg::S_DIV_INIT: begin
        if (sts_i.it_limit) begin
          st_d = psrf_pkg::StLimit; state_d = psrf_pkg::S_OUT;
        end else if (sts_i.f_equal) begin
          st_d = psrf_pkg::StZeroDen; state_d = psrf_pkg::S_OUT;
        end else begin
          state_d = psrf_pkg::S_DIV_RUN;
        end
      end
      psrf_pkg::S_DIV_RUN: if (sts_i.div_done) state_d = psrf_pkg::S_UPDATE;
      psrf_pkg::S_UPDATE: begin
        sel_d = psrf_pkg::EV_X2; state_d = psrf_pkg::S_EV_INIT;
      end
      psrf_pkg::S_TEST: begin
        if (sts_i.conv) begin
          st_d = psrf_pkg::StConverged; state_d = psrf_pkg::S_OUT;
        end else begin
          state_d = psrf_pkg::S_DIV_INIT;
        end
      end
      psrf_pkg::S_OUT: if (out_ready_i) state_d = psrf_pkg::S_IDLE;
      default: state_d = psrf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.ev_sel = sel_q;
    case (state_q)
      psrf_pkg::S_IDLE:     begin cmd_o.load_x = start_i; cmd_o.it_clr = start_i; end
      psrf_pkg::S_EV_INIT:  cmd_o.ev_init = 1'b1;
      psrf_pkg::S_EV_MUL:   cmd_o.ev_mul = 1'b1;
      psrf_pkg::S_EV_ADD:   cmd_o.ev_add = 1'b1;
      psrf_pkg::S_EV_DONE:  cmd_o.ev_store = 1'b1;
      psrf_pkg::S_DIV_INIT: cmd_o.div_init = 1'b1;
      psrf_pkg::S_DIV_RUN:  cmd_o.div_step = !sts_i.div_done;
      psrf_pkg::S_UPDATE:   cmd_o.update = 1'b1;
      psrf_pkg::S_TEST:     cmd_o.shift = !sts_i.conv;
      default: ;
    endcase
  end
  assign busy_o      = (state_q != psrf_pkg::S_IDLE);
  assign out_valid_o = (state_q == psrf_pkg::S_OUT);
  assign status_o    = st_q;
endmodule
`default_nettype wire
